@@ src/ttc_pkg.sv @@
// thermistor temperature converter package: types, register codes and constants
// used by the converter top level, its channel pipeline and its log2 unit
// no dependencies

package ttc_pkg;

  localparam int FRAC_BITS = 28;
  localparam int LOG_IN_W  = 52;
  localparam int P_W       = 6;
  localparam int LOG_OUT_W = P_W + FRAC_BITS;
  localparam int LOG_LAT   = FRAC_BITS + 2;
  localparam int DIV_STEPS = 17;
  localparam int CH_LAT    = 9 + LOG_LAT + DIV_STEPS + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [27:0] LN2_Q28 = 28'd186065280;

  localparam logic signed [16:0] INVALID_TEMP = 17'sd55599;
  localparam logic signed [16:0] MAX_TEMP     = 17'sd55598;
  localparam logic [16:0]        ZERO_C_CENTIK = 17'd27315;
  localparam logic [16:0]        MAX_CENTIK    = 17'd82913;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SUPPLY_LOW  = 3'd0,
    REG_SUPPLY_HIGH = 3'd1,
    REG_NOMINAL_RES = 3'd2,
    REG_BETA        = 3'd3,
    REG_NOMINAL_T   = 3'd4
  } ttc_reg_e;

  typedef struct packed {
    logic [19:0] r0;
    logic [13:0] beta;
    logic [15:0] k0;
  } ttc_cfg_t;

endpackage

@@ src/thermistor_temperature_converter.sv @@
// Three-channel thermistor converter. Takes one item per clock; the pipeline
// length is set by the two 30-stage log2 units and the 17-stage restoring
// divider in each channel, one register per stage. All stages advance together
// and hold while a finished result is stalled, so stall_o follows stall_i only
// while a result is waiting. Configuration registers take effect at once; the user
// must write them only while the block is empty, as the block does not enforce it.

module thermistor_temperature_converter #(
  parameter int SAMPLE_COUNT   = 5,
  parameter int ADC_FULL_SCALE = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic [9:0]                         check_supply_adc_i,
  input  logic [9:0]                         ref_supply_adc_i,
  input  logic [12:0]                        sum_a_i,
  input  logic [12:0]                        sum_b_i,
  input  logic [12:0]                        sum_c_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output logic                               supply_fault_o,
  output logic signed [16:0]                 temp_a_o,
  output logic signed [16:0]                 temp_b_o,
  output logic signed [16:0]                 temp_c_o,
  output logic                               valid_a_o,
  output logic                               valid_b_o,
  output logic                               valid_c_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ttc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ttc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import ttc_pkg::*;

  logic [9:0]         low_q, high_q;
  logic [19:0]        r0_q;
  logic [13:0]        beta_q, tnom_q;
  ttc_cfg_t           cfg;
  logic               en;
  logic [19:0]        chk, lo, hi;
  logic               fault_d;
  logic               vld_q   [CH_LAT];
  logic               fault_q [CH_LAT];
  logic signed [16:0] t_a, t_b, t_c;
  logic               ok_a, ok_b, ok_c;
  logic               flt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= 10'd270;
      high_q <= 10'd800;
      r0_q   <= 20'd10000;
      beta_q <= 14'd3950;
      tnom_q <= 14'd2500;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (ttc_reg_e'(cfg_index_i))
        REG_SUPPLY_LOW:  low_q  <= cfg_data_i[9:0];
        REG_SUPPLY_HIGH: high_q <= cfg_data_i[9:0];
        REG_NOMINAL_RES: r0_q   <= cfg_data_i;
        REG_BETA:        beta_q <= cfg_data_i[13:0];
        REG_NOMINAL_T:   tnom_q <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  assign cfg.r0   = r0_q;
  assign cfg.beta = beta_q;
  assign cfg.k0   = 16'(tnom_q) + 16'(ZERO_C_CENTIK);

  // supply window in centivolts
  assign chk     = 20'(check_supply_adc_i) * 20'd1000;
  assign lo      = 20'(low_q) * 20'd1025;
  assign hi      = 20'(high_q) * 20'd1025;
  assign fault_d = (chk < lo) || (chk > hi);

  assign en      = !(vld_q[CH_LAT-1] && stall_i);
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < CH_LAT; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= valid_i;
      for (int s = 1; s < CH_LAT; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fault_q[0] <= fault_d;
      for (int s = 1; s < CH_LAT; s++) begin
        fault_q[s] <= fault_q[s-1];
      end
    end
  end

  ttc_channel #(
    .SAMPLE_COUNT   (SAMPLE_COUNT),
    .ADC_FULL_SCALE (ADC_FULL_SCALE)
  ) u_ch_a (
    .clk_i  (clk_i),
    .en_i   (en),
    .sum_i  (sum_a_i),
    .ref_i  (ref_supply_adc_i),
    .cfg_i  (cfg),
    .temp_o (t_a),
    .ok_o   (ok_a)
  );

  ttc_channel #(
    .SAMPLE_COUNT   (SAMPLE_COUNT),
    .ADC_FULL_SCALE (ADC_FULL_SCALE)
  ) u_ch_b (
    .clk_i  (clk_i),
    .en_i   (en),
    .sum_i  (sum_b_i),
    .ref_i  (ref_supply_adc_i),
    .cfg_i  (cfg),
    .temp_o (t_b),
    .ok_o   (ok_b)
  );

  ttc_channel #(
    .SAMPLE_COUNT   (SAMPLE_COUNT),
    .ADC_FULL_SCALE (ADC_FULL_SCALE)
  ) u_ch_c (
    .clk_i  (clk_i),
    .en_i   (en),
    .sum_i  (sum_c_i),
    .ref_i  (ref_supply_adc_i),
    .cfg_i  (cfg),
    .temp_o (t_c),
    .ok_o   (ok_c)
  );

  assign flt            = fault_q[CH_LAT-1];
  assign valid_o        = vld_q[CH_LAT-1];
  assign supply_fault_o = flt;
  assign temp_a_o       = flt ? INVALID_TEMP : t_a;
  assign temp_b_o       = flt ? INVALID_TEMP : t_b;
  assign temp_c_o       = flt ? INVALID_TEMP : t_c;
  assign valid_a_o      = !flt && ok_a;
  assign valid_b_o      = !flt && ok_b;
  assign valid_c_o      = !flt && ok_c;

endmodule

@@ src/ttc_log2.sv @@
// pipelined log2 unit: msb search, normalize, then one squaring stage per fraction bit
// result is the msb position and 28 truncated fraction bits
// depends on ttc_pkg

module ttc_log2 (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [ttc_pkg::LOG_IN_W-1:0]  x_i,
  output logic [ttc_pkg::LOG_OUT_W-1:0] log_o
);
  import ttc_pkg::*;

  logic [LOG_IN_W-1:0]    x_q;
  logic [P_W-1:0]         pa_d, pa_q;
  logic [LOG_IN_W+30:0]   wide;
  logic [31:0]            m_q [FRAC_BITS+1];
  logic [P_W-1:0]         p_q [FRAC_BITS+1];
  logic [FRAC_BITS-1:0]   f_q [FRAC_BITS+1];
  logic [31:0]            m_d [FRAC_BITS];
  logic [FRAC_BITS-1:0]   f_d [FRAC_BITS];
  logic [63:0]            sq  [FRAC_BITS];
  logic [32:0]            tt  [FRAC_BITS];

  always_comb begin
    pa_d = '0;
    for (int i = 0; i < LOG_IN_W; i++) begin
      if (x_i[i]) begin
        pa_d = P_W'(i);
      end
    end
  end

  assign wide = {x_q, 31'd0} >> pa_q;

  always_comb begin
    for (int s = 0; s < FRAC_BITS; s++) begin
      sq[s]  = 64'(m_q[s]) * 64'(m_q[s]);
      tt[s]  = sq[s][63:31];
      f_d[s] = f_q[s];
      if (tt[s][32]) begin
        m_d[s] = tt[s][32:1];
        f_d[s][FRAC_BITS-1-s] = 1'b1;
      end else begin
        m_d[s] = tt[s][31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_i;
      pa_q   <= pa_d;
      m_q[0] <= wide[31:0];
      p_q[0] <= pa_q;
      f_q[0] <= '0;
      for (int s = 0; s < FRAC_BITS; s++) begin
        m_q[s+1] <= m_d[s];
        p_q[s+1] <= p_q[s];
        f_q[s+1] <= f_d[s];
      end
    end
  end

  assign log_o = {p_q[FRAC_BITS], f_q[FRAC_BITS]};

endmodule

@@ src/ttc_channel.sv @@
// one sensor channel: resistance ratio, two log2 units, ln scaling,
// b-parameter denominator and a restoring divider, all fully pipelined
// depends on ttc_pkg and ttc_log2

module ttc_channel #(
  parameter int SAMPLE_COUNT   = 5,
  parameter int ADC_FULL_SCALE = 1024
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [12:0]             sum_i,
  input  logic [9:0]              ref_i,
  input  ttc_pkg::ttc_cfg_t       cfg_i,
  output logic signed [16:0]      temp_o,
  output logic                    ok_o
);
  import ttc_pkg::*;

  localparam int unsigned SCALE = 2 * SAMPLE_COUNT * ADC_FULL_SCALE;

  // front end
  logic [23:0]           num_d, num1_q;
  logic [31:0]           refsc_d;
  logic [32:0]           den_d, den1_q;
  logic                  ok1_q, ok2_q;
  logic [LOG_IN_W-1:0]   x1_q, x2_q;
  logic                  ok_l_q [LOG_LAT];
  logic [LOG_OUT_W-1:0]  l1, l2;

  // ln scaling
  logic [34:0]           dif;
  logic                  neg3_q, neg4_q, neg5_q, neg6_q;
  logic [33:0]           mag3_q;
  logic [44:0]           plo4_q, phi4_q;
  logic [62:0]           lsum;
  logic [33:0]           lmag5_q;
  logic [32:0]           klo6_q, khi6_q;
  logic [29:0]           bk6_q;
  logic                  ok3_q, ok4_q, ok5_q, ok6_q, ok7_q, ok8_q;

  // denominator
  logic [49:0]           kl;
  logic [20:0]           b100;
  logic [51:0]           base, dq7_q;
  logic [36:0]           bkh7_q;
  logic [42:0]           dsh, dsh8_q;
  logic [57:0]           numer8_q;
  logic                  hot8_q;
  logic                  ovf;

  // divider
  logic [57:0]           r_q   [DIV_STEPS+1];
  logic [42:0]           dv_q  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0]  q_q   [DIV_STEPS+1];
  logic                  hot_q [DIV_STEPS+1];
  logic                  okd_q [DIV_STEPS+1];
  logic [57:0]           r_d   [DIV_STEPS];
  logic [DIV_STEPS-1:0]  q_d   [DIV_STEPS];
  logic [60:0]           shf   [DIV_STEPS];

  logic signed [16:0]    temp_d, temp_q;
  logic                  okf_q;

  assign num_d   = 24'({11'd0, sum_i} * 24'd1025);
  assign refsc_d = 32'(ref_i) * 32'(SCALE);
  assign den_d   = {1'b0, refsc_d} - {9'd0, num_d};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num1_q <= num_d;
      den1_q <= den_d;
      ok1_q  <= (sum_i != '0);
      x1_q   <= LOG_IN_W'(num1_q) * LOG_IN_W'(14'd10000);
      x2_q   <= LOG_IN_W'(den1_q[31:0]) * LOG_IN_W'(cfg_i.r0);
      ok2_q  <= ok1_q && !den1_q[32] && (den1_q != '0) &&
                (cfg_i.r0 != '0) && (cfg_i.beta != '0);
      ok_l_q[0] <= ok2_q;
      for (int s = 1; s < LOG_LAT; s++) begin
        ok_l_q[s] <= ok_l_q[s-1];
      end
    end
  end

  ttc_log2 u_log_num (
    .clk_i (clk_i),
    .en_i  (en_i),
    .x_i   (x1_q),
    .log_o (l1)
  );

  ttc_log2 u_log_den (
    .clk_i (clk_i),
    .en_i  (en_i),
    .x_i   (x2_q),
    .log_o (l2)
  );

  assign dif  = {1'b0, l1} - {1'b0, l2};
  assign lsum = {1'b0, phi4_q, 17'd0} + 63'(plo4_q) + 63'(64'd1 << (FRAC_BITS - 1));
  assign kl   = {khi6_q, 17'd0} + 50'(klo6_q);
  assign b100 = 21'(21'(cfg_i.beta) * 21'd100);
  assign base = {3'd0, b100, 28'd0};
  assign dsh  = dq7_q[50:8];
  assign ovf  = {3'd0, numer8_q} >= {1'b0, dsh8_q, 17'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg3_q  <= dif[34];
      mag3_q  <= dif[34] ? 34'(~dif + 35'd1) : dif[33:0];
      ok3_q   <= ok_l_q[LOG_LAT-1];
      plo4_q  <= 45'(mag3_q[16:0]) * 45'(LN2_Q28);
      phi4_q  <= 45'(mag3_q[33:17]) * 45'(LN2_Q28);
      neg4_q  <= neg3_q;
      ok4_q   <= ok3_q;
      lmag5_q <= lsum[61:28];
      neg5_q  <= neg4_q;
      ok5_q   <= ok4_q;
      klo6_q  <= 33'(lmag5_q[16:0]) * 33'(cfg_i.k0);
      khi6_q  <= 33'(lmag5_q[33:17]) * 33'(cfg_i.k0);
      bk6_q   <= 30'(cfg_i.beta) * 30'(cfg_i.k0);
      neg6_q  <= neg5_q;
      ok6_q   <= ok5_q;
      dq7_q   <= neg6_q ? (base - 52'(kl)) : (base + 52'(kl));
      bkh7_q  <= 37'(bk6_q) * 37'd100;
      ok7_q   <= ok6_q;
      dsh8_q  <= dsh;
      numer8_q <= {1'b0, bkh7_q, 20'd0} + 58'(dsh[42:1]);
      hot8_q  <= dq7_q[51] || (dsh == '0);
      ok8_q   <= ok7_q;
      r_q[0]   <= numer8_q;
      dv_q[0]  <= dsh8_q;
      q_q[0]   <= '0;
      hot_q[0] <= hot8_q || ovf;
      okd_q[0] <= ok8_q;
      for (int s = 0; s < DIV_STEPS; s++) begin
        r_q[s+1]   <= r_d[s];
        dv_q[s+1]  <= dv_q[s];
        q_q[s+1]   <= q_d[s];
        hot_q[s+1] <= hot_q[s];
        okd_q[s+1] <= okd_q[s];
      end
      temp_q <= temp_d;
      okf_q  <= okd_q[DIV_STEPS];
    end
  end

  always_comb begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      shf[s] = 61'(dv_q[s]) << (DIV_STEPS - 1 - s);
      r_d[s] = r_q[s];
      q_d[s] = q_q[s];
      if ({3'd0, r_q[s]} >= shf[s]) begin
        r_d[s] = 58'({3'd0, r_q[s]} - shf[s]);
        q_d[s][DIV_STEPS-1-s] = 1'b1;
      end
    end
  end

  always_comb begin
    if (!okd_q[DIV_STEPS]) begin
      temp_d = INVALID_TEMP;
    end else if (hot_q[DIV_STEPS] || (q_q[DIV_STEPS] > MAX_CENTIK)) begin
      temp_d = MAX_TEMP;
    end else begin
      temp_d = $signed(q_q[DIV_STEPS] - ZERO_C_CENTIK);
    end
  end

  assign temp_o = temp_q;
  assign ok_o   = okf_q;

endmodule

@@ src/ttc_checker.sv @@
// port-level checks for the thermistor converter, bound to the top level
// depends on ttc_pkg and thermistor_temperature_converter

module ttc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               stall_o,
  input logic               valid_o,
  input logic               stall_i,
  input logic               supply_fault_o,
  input logic signed [16:0] temp_a_o,
  input logic signed [16:0] temp_b_o,
  input logic signed [16:0] temp_c_o,
  input logic               valid_a_o,
  input logic               valid_b_o,
  input logic               valid_c_o
);
  import ttc_pkg::*;

  // a stalled result stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("result dropped while stalled");

  // input only held back while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without a waiting result");

  // fault kills every channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && supply_fault_o |-> !valid_a_o && !valid_b_o && !valid_c_o &&
      temp_a_o == INVALID_TEMP && temp_b_o == INVALID_TEMP && temp_c_o == INVALID_TEMP)
    else $error("supply fault with live channel");

  // invalid channel a carries the sentinel, valid channel a stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (valid_a_o || temp_a_o == INVALID_TEMP) &&
      (!valid_a_o || (temp_a_o <= MAX_TEMP && temp_a_o >= -17'sd27315)))
    else $error("channel a temperature inconsistent with its flag");

endmodule

bind thermistor_temperature_converter ttc_checker u_ttc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .stall_o        (stall_o),
  .valid_o        (valid_o),
  .stall_i        (stall_i),
  .supply_fault_o (supply_fault_o),
  .temp_a_o       (temp_a_o),
  .temp_b_o       (temp_b_o),
  .temp_c_o       (temp_c_o),
  .valid_a_o      (valid_a_o),
  .valid_b_o      (valid_b_o),
  .valid_c_o      (valid_c_o)
);

@@ dv/thermistor_temperature_converter_test.sv @@
// testbench for the three-channel thermistor temperature converter: drives items with
// random gaps and back pressure, predicts each result in fixed point and checks it
// depends on ttc_pkg and thermistor_temperature_converter

module thermistor_temperature_converter_test;
  import ttc_pkg::*;

  localparam int SAMPLES = 5;
  localparam int FULL_SCALE = 1024;
  localparam int QUIET_LIMIT = 5000;

  typedef struct {
    logic [9:0] check;
    logic [9:0] ref_adc;
    logic [12:0] sum [3];
  } reading_t;

  typedef struct {
    logic fault;
    logic signed [16:0] temp [3];
    logic ok [3];
  } temps_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic [9:0] check_supply_adc_i = '0;
  logic [9:0] ref_supply_adc_i = '0;
  logic [12:0] sum_a_i = '0;
  logic [12:0] sum_b_i = '0;
  logic [12:0] sum_c_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic supply_fault_o;
  logic signed [16:0] temp_a_o, temp_b_o, temp_c_o;
  logic valid_a_o, valid_b_o, valid_c_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic [9:0] low_cv, high_cv;
  logic [19:0] r0_ohms;
  logic [13:0] beta_k;
  logic [13:0] t0_centi;

  temps_t pending_temps [$];
  int errors = 0;
  int quiet = 0;
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  thermistor_temperature_converter uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint unsigned log2_fix(longint unsigned x);
    int p;
    longint unsigned m;
    longint unsigned frac;
    p = 63;
    frac = 0;
    while (p > 0 && !x[p]) p--;
    m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
    for (int i = FRAC_BITS - 1; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac |= 64'd1 << i;
      end
    end
    return (longint'(p) << FRAC_BITS) + frac;
  endfunction

  function automatic logic signed [16:0] channel_temp(input logic [12:0] sum,
                                                       input logic [9:0] ref_adc,
                                                       output logic ok);
    longint num, den, d, mag, lq, dq, b, k0, t;
    num = 1025 * longint'(sum);
    den = 2 * longint'(ref_adc) * SAMPLES * FULL_SCALE - num;
    b = longint'(beta_k);
    k0 = longint'(t0_centi) + 27315;
    ok = 1'b0;
    if (num <= 0 || den <= 0 || r0_ohms == 0 || b == 0) return INVALID_TEMP;
    ok = 1'b1;
    d = longint'(log2_fix(10000 * num)) - longint'(log2_fix(den * longint'(r0_ohms)));
    mag = (d < 0) ? -d : d;
    mag = (mag * longint'(LN2_Q28) + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    lq = (d < 0) ? -mag : mag;
    dq = ((100 * b) << FRAC_BITS) + k0 * lq;
    if (dq <= 0) return MAX_TEMP;
    dq = dq >> 8;
    if (dq <= 0) return MAX_TEMP;
    t = (((b * k0 * 100) << 20) + dq / 2) / dq;
    if (t > 82913) return MAX_TEMP;
    return 17'(t - 27315);
  endfunction

  function automatic temps_t convert_reading(input reading_t r);
    temps_t e;
    longint v;
    v = longint'(r.check) * 1000;
    e.fault = (v < longint'(low_cv) * 1025) || (v > longint'(high_cv) * 1025);
    for (int c = 0; c < 3; c++) begin
      if (e.fault) begin
        e.temp[c] = INVALID_TEMP;
        e.ok[c] = 1'b0;
      end else begin
        e.temp[c] = channel_temp(r.sum[c], r.ref_adc, e.ok[c]);
      end
    end
    return e;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk_i) begin
    temps_t e;
    logic signed [16:0] t_got [3];
    logic ok_got [3];
    if (rst_ni && valid_o && !stall_i) begin
      t_got = '{temp_a_o, temp_b_o, temp_c_o};
      ok_got = '{valid_a_o, valid_b_o, valid_c_o};
      if (pending_temps.size() == 0) begin
        report("unexpected item", 0, 0);
      end else begin
        e = pending_temps.pop_front();
        if (supply_fault_o !== e.fault) report("supply_fault", supply_fault_o, e.fault);
        for (int c = 0; c < 3; c++) begin
          if (t_got[c] !== e.temp[c]) report($sformatf("temp[%0d]", c), t_got[c], e.temp[c]);
          if (ok_got[c] !== e.ok[c]) report($sformatf("valid[%0d]", c), ok_got[c], e.ok[c]);
        end
      end
    end
  end

  // receiver stalls, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 200;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_i <= 1'b1;
    end else begin
      stall_i <= recv_idle && ($urandom_range(99) < 36);
    end
  end

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i) || (cfg_valid_i && cfg_ready_o))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("** thermistor_temperature_converter: FAILED **");
      $finish;
    end
  end

  task automatic send_reading(input reading_t r);
    while (send_idle && $urandom_range(99) < 36) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i <= 1'b1;
    check_supply_adc_i <= r.check;
    ref_supply_adc_i <= r.ref_adc;
    sum_a_i <= r.sum[0];
    sum_b_i <= r.sum[1];
    sum_c_i <= r.sum[2];
    do @(posedge clk_i); while (stall_o);
    pending_temps.push_back(convert_reading(r));
    @(negedge clk_i);
  endtask

  task automatic drain;
    valid_i <= 1'b0;
    while (pending_temps.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input ttc_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SUPPLY_LOW: low_cv = data[9:0];
      REG_SUPPLY_HIGH: high_cv = data[9:0];
      REG_NOMINAL_RES: r0_ohms = data;
      REG_BETA: beta_k = data[13:0];
      REG_NOMINAL_T: t0_centi = data[13:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input int lo, input int hi, input int r0, input int b, input int t0);
    write_reg(REG_SUPPLY_LOW, CFG_DATA_W'(lo));
    write_reg(REG_SUPPLY_HIGH, CFG_DATA_W'(hi));
    write_reg(REG_NOMINAL_RES, CFG_DATA_W'(r0));
    write_reg(REG_BETA, CFG_DATA_W'(b));
    write_reg(REG_NOMINAL_T, CFG_DATA_W'(t0));
  endtask

  function automatic reading_t make_reading(input int chk, input int rf,
                                            input int a, input int b, input int c);
    reading_t r;
    r.check = 10'(chk);
    r.ref_adc = 10'(rf);
    r.sum = '{13'(a), 13'(b), 13'(c)};
    return r;
  endfunction

  // mostly in-window supply and divider sums that give a real resistance
  function automatic reading_t random_reading;
    reading_t r;
    int lo_adc, hi_adc;
    lo_adc = (int'(low_cv) * 1025 + 999) / 1000;
    hi_adc = int'(high_cv) * 1025 / 1000;
    if (hi_adc > 1023) hi_adc = 1023;
    if ($urandom_range(99) < 80 && lo_adc <= hi_adc)
      r.check = 10'($urandom_range(hi_adc, lo_adc));
    else
      r.check = 10'($urandom_range(1023));
    r.ref_adc = ($urandom_range(3) == 0) ? 10'($urandom_range(1023)) :
                                           10'($urandom_range(1023, 400));
    for (int c = 0; c < 3; c++) begin
      case ($urandom_range(9))
        0: r.sum[c] = 13'($urandom_range(8191));
        1: r.sum[c] = 13'($urandom_range(20));
        default: r.sum[c] = 13'($urandom_range(5115));
      endcase
    end
    return r;
  endfunction

  task automatic run_random(input int n);
    repeat (n) send_reading(random_reading());
  endtask

  task automatic test_directed;
    send_reading(make_reading(0, 1023, 100, 100, 100));
    send_reading(make_reading(1023, 1023, 100, 100, 100));
    send_reading(make_reading(276, 1023, 2000, 2000, 2000));
    send_reading(make_reading(277, 1023, 2000, 2000, 2000));
    send_reading(make_reading(820, 1023, 2000, 2000, 2000));
    send_reading(make_reading(821, 1023, 2000, 2000, 2000));
    send_reading(make_reading(512, 1023, 0, 5115, 8191));
    send_reading(make_reading(512, 0, 100, 0, 5115));
    send_reading(make_reading(512, 1023, 1, 2, 3));
    send_reading(make_reading(512, 500, 4995, 4994, 4996));
    send_reading(make_reading(512, 1023, 5115, 5115, 5115));
    send_reading(make_reading(512, 1023, 8191, 8190, 4096));
    send_reading(make_reading(512, 682, 2557, 1000, 4000));
    send_reading(make_reading(512, 1023, 2557, 2558, 2559));
    send_reading(make_reading(512, 341, 1, 3410, 3000));
  endtask

  task automatic test_random_idle;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    run_random(500);
  endtask

  task automatic test_streaming;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    run_random(300);
  endtask

  task automatic test_backpressure;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_req = 1'b1;
    run_random(100);
    recv_idle = 1'b1;
  endtask

  task automatic test_drain_pause;
    send_idle = 1'b1;
    run_random(50);
    drain();
    run_random(50);
  endtask

  task automatic test_config_sweep;
    set_config(0, 1023, 100, 1000, 0);
    run_random(150);
    set_config(1023, 0, 1048575, 16383, 16383);
    run_random(50);
    set_config(300, 700, 1048575, 16383, 16383);
    run_random(150);
    set_config(200, 900, 0, 3950, 2500);
    run_random(100);
    set_config(200, 900, 10000, 0, 2500);
    run_random(100);
    set_config(682, 341, 699050, 10922, 10922);
    run_random(50);
    set_config(0, 1000, 470, 10000, 10000);
    run_random(150);
  endtask

  initial begin
    low_cv = 10'd270;
    high_cv = 10'd800;
    r0_ohms = 20'd10000;
    beta_k = 14'd3950;
    t0_centi = 14'd2500;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_idle();
    test_streaming();
    test_backpressure();
    test_drain_pause();
    test_config_sweep();
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("** thermistor_temperature_converter: PASSED **");
    end else begin
      $display("** thermistor_temperature_converter: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/ttc_pkg.sv
src/ttc_log2.sv
src/ttc_channel.sv
src/thermistor_temperature_converter.sv
src/ttc_checker.sv
dv/thermistor_temperature_converter_test.sv
